/* rtl/id_to_value_table_top_macros.svh */
// Assertion macros used by the id_to_value_table datapath (itvt_dp).
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ID_TO_VALUE_TABLE_TOP_MACROS_SVH
`define ID_TO_VALUE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ITVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itvt assertion failed");

// Next-cycle implication, checked outside reset
`define ITVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itvt assertion failed");

`endif

/* rtl/itvt_pkg.sv */
// Shared constants, codes and controller/datapath interface types
// for the id_to_value_table block. No dependencies.
package itvt_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECNT_W   = 7;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_HAS   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PUT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DROP  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_AT    = 3'd6;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

  // Read address selects
  localparam logic [1:0] RD_SCAN = 2'd0;
  localparam logic [1:0] RD_SLOT = 2'd1;
  localparam logic [1:0] RD_LAST = 2'd2;
  localparam logic [1:0] RD_POS  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                scan;
    logic [1:0]          rd_sel;
    logic                cap_val;
    logic                cap_key;
    logic                wr_append;
    logic                wr_update;
    logic                wr_move;
    logic                clr_count;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                finish;
  } itvt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit_now;
    logic              miss_now;
    logic              hit;
    logic              full;
    logic              pos_ok;
    logic              out_free;
  } itvt_sts_t;

endpackage

/* rtl/itvt_dp.sv */
// Datapath of the id_to_value_table: key/value memories, scan pointer,
// live count and output register. Depends on itvt_pkg and the macro header.
`include "id_to_value_table_top_macros.svh"

module itvt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [itvt_pkg::FUNC_W-1:0]          in_func,
  input  logic [itvt_pkg::KEY_W-1:0]           in_key,
  input  logic [itvt_pkg::VALUE_WIDTH-1:0]     in_value,
  input  logic [itvt_pkg::POS_W-1:0]           in_position,
  input  itvt_pkg::itvt_cmd_t                  cmd,
  output itvt_pkg::itvt_sts_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [itvt_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_found,
  output logic [itvt_pkg::KEY_W-1:0]           out_key,
  output logic [itvt_pkg::VALUE_WIDTH-1:0]     out_value,
  output logic [itvt_pkg::ECNT_W-1:0]          out_count
);

  // Request registers
  logic [itvt_pkg::FUNC_W-1:0]      func_r;
  logic [itvt_pkg::KEY_W-1:0]       key_r;
  logic [itvt_pkg::VALUE_WIDTH-1:0] value_r;
  logic [itvt_pkg::POS_W-1:0]       pos_r;

  // Table state and scan state
  logic [itvt_pkg::CNT_W-1:0]       count_r;
  logic [itvt_pkg::CNT_W-1:0]       count_nxt;
  logic [itvt_pkg::CNT_W-1:0]       ptr_r;
  logic [itvt_pkg::CNT_W-1:0]       ptr_dec;
  logic [itvt_pkg::CNT_W-1:0]       last_cnt;
  logic                             cmp_v_r;
  logic [itvt_pkg::ADDR_W-1:0]      cmp_addr_r;
  logic                             hit_r;
  logic [itvt_pkg::ADDR_W-1:0]      slot_r;

  // Result build registers
  logic [itvt_pkg::STATUS_W-1:0]    status_r;
  logic [itvt_pkg::KEY_W-1:0]       kout_r;
  logic [itvt_pkg::VALUE_WIDTH-1:0] vout_r;

  // Output register
  logic                             out_valid_r;
  logic [itvt_pkg::STATUS_W-1:0]    out_status_r;
  logic                             out_found_r;
  logic [itvt_pkg::KEY_W-1:0]       out_key_r;
  logic [itvt_pkg::VALUE_WIDTH-1:0] out_value_r;
  logic [itvt_pkg::ECNT_W-1:0]      out_count_r;

  // Memories and their ports
  logic [itvt_pkg::KEY_W-1:0]       key_mem [itvt_pkg::DEPTH];
  logic [itvt_pkg::VALUE_WIDTH-1:0] val_mem [itvt_pkg::DEPTH];
  logic [itvt_pkg::KEY_W-1:0]       key_rd_r;
  logic [itvt_pkg::VALUE_WIDTH-1:0] val_rd_r;
  logic [itvt_pkg::ADDR_W-1:0]      rd_addr;
  logic [itvt_pkg::ADDR_W-1:0]      wr_addr;
  logic [itvt_pkg::KEY_W-1:0]       wr_key;
  logic [itvt_pkg::VALUE_WIDTH-1:0] wr_val;
  logic                             wr_key_en;
  logic                             wr_val_en;
  logic                             hit_now;

  assign ptr_dec  = ptr_r - 1'b1;
  assign last_cnt = count_r - 1'b1;
  assign hit_now  = cmp_v_r && (key_rd_r == key_r);

  // Select the read address
  always_comb begin
    unique case (cmd.rd_sel)
      itvt_pkg::RD_SCAN: rd_addr = ptr_dec[itvt_pkg::ADDR_W-1:0];
      itvt_pkg::RD_SLOT: rd_addr = slot_r;
      itvt_pkg::RD_LAST: rd_addr = last_cnt[itvt_pkg::ADDR_W-1:0];
      itvt_pkg::RD_POS:  rd_addr = itvt_pkg::ADDR_W'(pos_r);
      default:           rd_addr = slot_r;
    endcase
  end

  // Write port: append at the end, otherwise at the hit slot
  assign wr_addr   = cmd.wr_append ? count_r[itvt_pkg::ADDR_W-1:0] : slot_r;
  assign wr_key    = cmd.wr_move ? key_rd_r : key_r;
  assign wr_val    = cmd.wr_move ? val_rd_r : value_r;
  assign wr_key_en = cmd.wr_append | cmd.wr_move;
  assign wr_val_en = cmd.wr_append | cmd.wr_update | cmd.wr_move;

  // Memory access with registered read data
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_r <= key_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
  end

  // Next live count
  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.wr_append) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.wr_move) begin
      count_nxt = last_cnt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        cmp_v_r <= 1'b0;
        hit_r   <= 1'b0;
      end else if (cmd.scan) begin
        if (hit_now) begin
          hit_r   <= 1'b1;
          cmp_v_r <= 1'b0;
        end else begin
          cmp_v_r <= (ptr_r != '0);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, scan pointer and result build
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      key_r    <= in_key;
      value_r  <= in_value;
      pos_r    <= in_position;
      ptr_r    <= (in_func <= itvt_pkg::FN_DROP) ? count_r : '0;
      status_r <= itvt_pkg::ST_OK;
      kout_r   <= '0;
      vout_r   <= '0;
    end else begin
      if (cmd.scan) begin
        cmp_addr_r <= rd_addr;
        if (hit_now) begin
          slot_r <= cmp_addr_r;
        end else if (ptr_r != '0) begin
          ptr_r <= ptr_dec;
        end
      end
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.cap_val) begin
        vout_r <= val_rd_r;
      end
      if (cmd.cap_key) begin
        kout_r <= key_rd_r;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_r;
      out_found_r  <= hit_r;
      out_key_r    <= kout_r;
      out_value_r  <= vout_r;
      out_count_r  <= itvt_pkg::ECNT_W'(count_r);
    end
  end

  assign sts.func     = func_r;
  assign sts.hit_now  = hit_now;
  assign sts.miss_now = !cmp_v_r && (ptr_r == '0);
  assign sts.hit      = hit_r;
  assign sts.full     = (count_r == itvt_pkg::CNT_W'(itvt_pkg::DEPTH));
  assign sts.pos_ok   = (itvt_pkg::CNT_W'(pos_r) < count_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_key    = out_key_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;

  `ITVT_ASSERT_IMP(a_count_max, 1'b1, count_r <= itvt_pkg::CNT_W'(itvt_pkg::DEPTH))
  `ITVT_ASSERT_IMP(a_append_room, cmd.wr_append, !sts.full && !hit_r)
  `ITVT_ASSERT_IMP(a_move_hit, cmd.wr_move, hit_r && (count_r != '0))
  `ITVT_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r)
  `ITVT_ASSERT_IMP(a_finish_free, cmd.finish, !out_valid_r || out_ready)

endmodule

/* rtl/itvt_ctrl.sv */
// Controller state machine of the id_to_value_table: sequences the
// scan, reads, writes and result hand-off. Depends on itvt_pkg.
module itvt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itvt_pkg::itvt_sts_t sts,
  output itvt_pkg::itvt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ACT    = 3'd2;
  localparam logic [2:0] S_CAPV   = 3'd3;
  localparam logic [2:0] S_CAPKV  = 3'd4;
  localparam logic [2:0] S_RDLAST = 3'd5;
  localparam logic [2:0] S_MOVE   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = itvt_pkg::RD_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit_now || sts.miss_now) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        state_nxt = S_DONE;
        unique case (sts.func) inside
          itvt_pkg::FN_HAS: begin
          end
          itvt_pkg::FN_ADD, itvt_pkg::FN_SET: begin
            if (sts.hit) begin
              if (sts.func == itvt_pkg::FN_ADD) begin
                cmd.set_status = 1'b1;
                cmd.status     = itvt_pkg::ST_EXISTS;
              end else begin
                cmd.wr_update = 1'b1;
              end
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = itvt_pkg::ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
            end
          end
          itvt_pkg::FN_PUT: begin
            if (sts.hit) begin
              cmd.wr_update = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = itvt_pkg::ST_NOT_FOUND;
            end
          end
          itvt_pkg::FN_GET, itvt_pkg::FN_DROP: begin
            if (sts.hit) begin
              cmd.rd_sel = itvt_pkg::RD_SLOT;
              state_nxt  = (sts.func == itvt_pkg::FN_GET) ? S_CAPV : S_RDLAST;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = itvt_pkg::ST_NOT_FOUND;
            end
          end
          itvt_pkg::FN_AT: begin
            if (sts.pos_ok) begin
              cmd.rd_sel = itvt_pkg::RD_POS;
              state_nxt  = S_CAPKV;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = itvt_pkg::ST_BAD_POS;
            end
          end
          itvt_pkg::FN_CLEAR: begin
            cmd.clr_count = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_CAPV: begin
        cmd.cap_val = 1'b1;
        state_nxt   = S_DONE;
      end
      S_CAPKV: begin
        cmd.cap_val = 1'b1;
        cmd.cap_key = 1'b1;
        state_nxt   = S_DONE;
      end
      S_RDLAST: begin
        // dropped value is on the read port now; fetch the last entry
        cmd.cap_val = 1'b1;
        cmd.rd_sel  = itvt_pkg::RD_LAST;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/id_to_value_table_top.sv */
// Top level of the id_to_value_table: stream port packing around the
// controller (itvt_ctrl) and datapath (itvt_dp). Depends on itvt_pkg.
//
//   channel | direction | handshake            | content
//   in_     | slave     | in_tvalid/in_tready   | tuser: func; tdata: key, value, position
//   out_    | master    | out_tvalid/out_tready | tdata: status, found, key_out,
//           |           |                       |        value_out, entry_count
//
// One item at a time; lookups read one stored key per cycle, last entry first.
// A get then reads the stored value; a drop also moves the last entry into the
// freed slot. Reset clears the live count, the output valid and the controller
// state, but not the stored entries.
// A finished result waits in the output register while the next item is
// accepted and worked on; a stalled output holds the block before hand-off.
module id_to_value_table_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] key, [47:16] value, [53:48] position, [55:54] zero
  input  logic [itvt_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] func
  input  logic [itvt_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] status, [3] found, [19:4] key_out, [51:20] value_out,
  // [58:52] entry_count, [63:59] zero
  output logic [itvt_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  itvt_pkg::itvt_cmd_t              cmd;
  itvt_pkg::itvt_sts_t              sts;
  logic [itvt_pkg::STATUS_W-1:0]    res_status;
  logic                             res_found;
  logic [itvt_pkg::KEY_W-1:0]       res_key;
  logic [itvt_pkg::VALUE_WIDTH-1:0] res_value;
  logic [itvt_pkg::ECNT_W-1:0]      res_count;

  itvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itvt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_tuser),
    .in_key      (in_tdata[15:0]),
    .in_value    (in_tdata[47:16]),
    .in_position (in_tdata[53:48]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_found   (res_found),
    .out_key     (res_key),
    .out_value   (res_value),
    .out_count   (res_count)
  );

  // Pack the result item
  assign out_tdata = {5'b0, res_count, res_value, res_key, res_found, res_status};

endmodule
